// File: src/fws_pkg.sv
// Shared widths, register indexes, reset values and divider response type.
`default_nettype none
package fws_pkg;

    localparam int TICKS_W   = 32;
    localparam int RATE_W    = 24;
    localparam int TOTAL_W   = 48;
    localparam int WS_W      = 7;
    localparam int TR_W      = 32;
    localparam int SCALED_W  = TR_W + 8;
    localparam int CFG_IDX_W = 2;
    localparam int IN_W      = 32;
    localparam int OUT_W     = TICKS_W + 4 * RATE_W + TOTAL_W;

    localparam int DEF_MAX_WINDOW = 64;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TICK_RATE   = 2'd1;

    localparam logic [WS_W-1:0] WS_RESET = 7'd32;
    localparam logic [TR_W-1:0] TR_RESET = 32'd1000000;

    localparam logic [RATE_W-1:0] RATE_SAT = {RATE_W{1'b1}};

    typedef struct packed {
        logic              done;
        logic [RATE_W-1:0] quot;
    } div_rsp_t;

endpackage
`default_nettype wire

// File: src/fws_ring.sv
// Duration ring: one write port, one read port with registered read data.
`default_nettype none
module fws_ring
    import fws_pkg::*;
#(
    parameter int DEPTH = DEF_MAX_WINDOW,
    parameter int IDX_W = 6
) (
    input  wire logic               aclk,
    input  wire logic               wr_en,
    input  wire logic [IDX_W-1:0]   wr_addr,
    input  wire logic [TICKS_W-1:0] wr_data,
    input  wire logic               rd_en,
    input  wire logic [IDX_W-1:0]   rd_addr,
    output      logic [TICKS_W-1:0] rd_data_reg
);

    logic [TICKS_W-1:0] ring_mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            ring_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= ring_mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

// File: src/fws_div.sv
// Serial restoring divider: 24-bit saturating quotient, one bit per cycle.
`default_nettype none
module fws_div
    import fws_pkg::*;
#(
    parameter int NUM_W = 47,
    parameter int DEN_W = 39
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output      div_rsp_t         rsp
);

    localparam int CNT_DW = $clog2(RATE_W);
    localparam logic [CNT_DW-1:0] LAST_BIT = CNT_DW'(RATE_W - 1);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_DW-1:0] cnt_reg;
    logic [DEN_W-1:0]  rem_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [RATE_W-1:0] low_reg;
    logic [RATE_W-1:0] quot_reg;

    logic [DEN_W-1:0]  num_hi;
    logic              sat;
    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    diff;
    logic              ge;

    // quotient overflows 24 bits exactly when num / 2^24 >= den
    assign num_hi = DEN_W'(num[NUM_W-1:RATE_W]);
    assign sat    = (num_hi >= den);
    assign trial  = {rem_reg, low_reg[RATE_W-1]};
    assign diff   = trial - {1'b0, den_reg};
    assign ge     = (trial >= {1'b0, den_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            if (start) begin
                if (den == '0) begin
                    quot_reg <= '0;
                    done_reg <= 1'b1;
                end else if (sat) begin
                    quot_reg <= RATE_SAT;
                    done_reg <= 1'b1;
                end else begin
                    busy_reg <= 1'b1;
                    done_reg <= 1'b0;
                    cnt_reg  <= '0;
                    rem_reg  <= num_hi;
                    den_reg  <= den;
                    low_reg  <= num[RATE_W-1:0];
                end
            end else if (busy_reg) begin
                rem_reg  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                quot_reg <= {quot_reg[RATE_W-2:0], ge};
                low_reg  <= {low_reg[RATE_W-2:0], 1'b0};
                cnt_reg  <= cnt_reg + 1'b1;
                done_reg <= (cnt_reg == LAST_BIT);
                if (cnt_reg == LAST_BIT) begin
                    busy_reg <= 1'b0;
                end
            end else begin
                done_reg <= 1'b0;
            end
        end
    end

    assign rsp = '{done: done_reg, quot: quot_reg};

endmodule
`default_nettype wire

// File: src/frame_rate_window_stats.sv
// Steps from accept to result word: ring walk over the window fill, multiply, the
// four divisions, output load. Input is accepted only in idle, so a word is taken
// only after the last result word is loaded; the ring's single read port sets the
// walk, one shared serial divider the four rates; an untaken result word stalls input.
// Reset (aresetn low, synchronous): window_size 32, tick_rate 1000000, ring
// empty, frame count zero, output empty. Ring contents need no clearing.
`default_nettype none
module frame_rate_window_stats
    import fws_pkg::*;
#(
    parameter int MAX_WINDOW = DEF_MAX_WINDOW
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // configuration
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [TR_W-1:0]      cfg_wdata,
    // input stream
    input  wire logic                 s_tvalid,
    output      logic                 s_tready,
    input  wire logic [IN_W-1:0]      s_tdata,  // frame_ticks
    // result stream
    output      logic                 m_tvalid,
    input  wire logic                 m_tready,
    // last_frame_ticks, current_rate, min_rate, max_rate, average_rate, frames_seen
    output      logic [OUT_W-1:0]     m_tdata
);

    localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CNT_W = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W = TICKS_W + CNT_W;
    localparam int NUM_W = SCALED_W + CNT_W;
    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(MAX_WINDOW - 1);
    localparam logic [CNT_W-1:0] MAX_CNT   = CNT_W'(MAX_WINDOW);

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_WALK      = 3'd1;
    localparam logic [2:0] S_MUL       = 3'd2;
    localparam logic [2:0] S_DIV_START = 3'd3;
    localparam logic [2:0] S_DIV_WAIT  = 3'd4;
    localparam logic [2:0] S_DONE      = 3'd5;

    localparam logic [1:0] DIV_CUR = 2'd0;
    localparam logic [1:0] DIV_MIN = 2'd1;
    localparam logic [1:0] DIV_MAX = 2'd2;
    localparam logic [1:0] DIV_AVG = 2'd3;

    function automatic logic [CNT_W-1:0] eff_win(input logic [WS_W-1:0] ws);
        logic [CNT_W-1:0] w;
        if (ws == '0) begin
            w = CNT_W'(1);
        end else if (32'(ws) > 32'(MAX_WINDOW)) begin
            w = MAX_CNT;
        end else begin
            w = CNT_W'(ws);
        end
        return w;
    endfunction

    logic [2:0]          state_reg;
    logic [WS_W-1:0]     ws_reg;
    logic [TR_W-1:0]     tick_rate_reg;
    logic [IDX_W-1:0]    slot_reg;
    logic [CNT_W-1:0]    filled_reg;
    logic [TOTAL_W-1:0]  total_reg;
    logic [TICKS_W-1:0]  ticks_reg;
    logic [SCALED_W-1:0] scaled_reg;
    logic [IDX_W-1:0]    rd_ptr_reg;
    logic [CNT_W-1:0]    iss_cnt_reg;
    logic                rd_vld_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [TICKS_W-1:0]  short_reg;
    logic [TICKS_W-1:0]  long_reg;
    logic [NUM_W-1:0]    prod_reg;
    logic [1:0]          sel_reg;
    logic [RATE_W-1:0]   cur_rate_reg;
    logic [RATE_W-1:0]   min_rate_reg;
    logic [RATE_W-1:0]   max_rate_reg;
    logic [RATE_W-1:0]   avg_rate_reg;
    logic                m_tvalid_reg;
    logic [OUT_W-1:0]    m_tdata_reg;

    logic [CNT_W-1:0]    win_eff;
    logic [CNT_W-1:0]    fill_clamp;
    logic [CNT_W-1:0]    filled_next;
    logic [CNT_W-1:0]    fill_cfg;
    logic [IDX_W-1:0]    slot_next;
    logic [IDX_W-1:0]    rd_ptr_next;
    logic                s_accept;
    logic                rd_issue;
    logic [TICKS_W-1:0]  rd_data;
    logic                div_start;
    logic [NUM_W-1:0]    div_num;
    logic [SUM_W-1:0]    div_den;
    div_rsp_t            div_rsp;

    assign s_tready  = (state_reg == S_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign rd_issue  = (state_reg == S_WALK) && (iss_cnt_reg < filled_reg);
    assign div_start = (state_reg == S_DIV_START);

    assign win_eff     = eff_win(ws_reg);
    assign fill_clamp  = (filled_reg > win_eff) ? win_eff : filled_reg;
    assign filled_next = (fill_clamp < win_eff) ? fill_clamp + 1'b1 : fill_clamp;
    assign fill_cfg    = (filled_reg > eff_win(cfg_wdata[WS_W-1:0])) ?
                         eff_win(cfg_wdata[WS_W-1:0]) : filled_reg;
    assign slot_next   = (slot_reg == LAST_SLOT) ? '0 : slot_reg + 1'b1;
    assign rd_ptr_next = (rd_ptr_reg == '0) ? LAST_SLOT : rd_ptr_reg - 1'b1;

    always_comb begin
        case (sel_reg)
            DIV_CUR: begin
                div_num = NUM_W'(scaled_reg);
                div_den = SUM_W'(ticks_reg);
            end
            DIV_MIN: begin
                div_num = NUM_W'(scaled_reg);
                div_den = SUM_W'(long_reg);
            end
            DIV_MAX: begin
                div_num = NUM_W'(scaled_reg);
                div_den = SUM_W'(short_reg);
            end
            default: begin
                div_num = prod_reg;
                div_den = sum_reg;
            end
        endcase
    end

    fws_ring #(
        .DEPTH (MAX_WINDOW),
        .IDX_W (IDX_W)
    ) u_ring (
        .aclk        (aclk),
        .wr_en       (s_accept),
        .wr_addr     (slot_reg),
        .wr_data     (s_tdata[TICKS_W-1:0]),
        .rd_en       (rd_issue),
        .rd_addr     (rd_ptr_reg),
        .rd_data_reg (rd_data)
    );

    fws_div #(
        .NUM_W (NUM_W),
        .DEN_W (SUM_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .rsp     (div_rsp)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            ws_reg        <= WS_RESET;
            tick_rate_reg <= TR_RESET;
            slot_reg      <= '0;
            filled_reg    <= '0;
            total_reg     <= '0;
            rd_vld_reg    <= 1'b0;
            sel_reg       <= DIV_CUR;
            m_tvalid_reg  <= 1'b0;
        end else begin
            // a word taken while the next one loads is replaced in S_DONE
            if (m_tvalid_reg && m_tready && (state_reg != S_DONE)) begin
                m_tvalid_reg <= 1'b0;
            end

            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_WINDOW_SIZE: begin
                        ws_reg     <= cfg_wdata[WS_W-1:0];
                        filled_reg <= fill_cfg;
                    end
                    REG_TICK_RATE: begin
                        tick_rate_reg <= cfg_wdata;
                    end
                    default: begin
                    end
                endcase
            end

            case (state_reg)
                S_IDLE: begin
                    if (s_accept) begin
                        slot_reg    <= slot_next;
                        filled_reg  <= filled_next;
                        total_reg   <= total_reg + 1'b1;
                        ticks_reg   <= s_tdata[TICKS_W-1:0];
                        scaled_reg  <= {tick_rate_reg, 8'h00};
                        rd_ptr_reg  <= slot_reg;   // newest word first
                        iss_cnt_reg <= '0;
                        sum_reg     <= '0;
                        short_reg   <= '0;
                        long_reg    <= '0;
                        state_reg   <= S_WALK;
                    end
                end
                S_WALK: begin
                    rd_vld_reg <= rd_issue;
                    if (rd_issue) begin
                        rd_ptr_reg  <= rd_ptr_next;
                        iss_cnt_reg <= iss_cnt_reg + 1'b1;
                    end
                    if (rd_vld_reg) begin
                        sum_reg <= sum_reg + SUM_W'(rd_data);
                        // zero durations stay out of min/max; zero short means none yet
                        if (rd_data != '0) begin
                            if (short_reg == '0 || rd_data < short_reg) begin
                                short_reg <= rd_data;
                            end
                            if (rd_data > long_reg) begin
                                long_reg <= rd_data;
                            end
                        end
                    end
                    if (!rd_issue && !rd_vld_reg) begin
                        state_reg <= S_MUL;
                    end
                end
                S_MUL: begin
                    prod_reg  <= NUM_W'(scaled_reg) * NUM_W'(filled_reg);
                    sel_reg   <= DIV_CUR;
                    state_reg <= S_DIV_START;
                end
                S_DIV_START: begin
                    state_reg <= S_DIV_WAIT;
                end
                S_DIV_WAIT: begin
                    if (div_rsp.done) begin
                        case (sel_reg)
                            DIV_CUR: cur_rate_reg <= div_rsp.quot;
                            DIV_MIN: min_rate_reg <= div_rsp.quot;
                            DIV_MAX: max_rate_reg <= div_rsp.quot;
                            default: avg_rate_reg <= div_rsp.quot;
                        endcase
                        if (sel_reg == DIV_AVG) begin
                            state_reg <= S_DONE;
                        end else begin
                            sel_reg   <= sel_reg + 1'b1;
                            state_reg <= S_DIV_START;
                        end
                    end
                end
                S_DONE: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tdata_reg  <= {total_reg, avg_rate_reg, max_rate_reg,
                                         min_rate_reg, cur_rate_reg, ticks_reg};
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_fill_in_window: assert property (@(posedge aclk) disable iff (!aresetn)
        filled_reg <= win_eff)
        else $error("window fill exceeds effective window size");

    a_accept_walks: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> (state_reg == S_WALK))
        else $error("accepted word did not start the ring walk");

    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> ($past(state_reg) == S_DONE))
        else $error("result word raised outside the completion state");

    a_div_done_waited: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> (state_reg == S_DIV_WAIT))
        else $error("divider finished while not awaited");

endmodule
`default_nettype wire
